// File: rtl/qspe_pkg.sv
// ----------------------------------------------------------------------------
// qspe_pkg
// Shared types and constants for the shortest path engine.
// ----------------------------------------------------------------------------
package qspe_pkg;

  localparam int MaxNodes   = 1024;
  localparam int MaxEdges   = 8192;
  localparam int WeightBits = 16;
  localparam int NodeBits   = $clog2(MaxNodes);
  localparam int EdgeBits   = $clog2(MaxEdges);
  localparam int EptrBits   = EdgeBits + 1;
  localparam int DistBits   = 27;
  localparam int OutBits    = 26;
  localparam int CntBits    = 11;
  localparam int EntryBits  = NodeBits + WeightBits + EptrBits;

  localparam logic [DistBits-1:0] DistInf = {DistBits{1'b1}};
  localparam logic [OutBits-1:0]  DistMax = {OutBits{1'b1}};
  localparam logic [EptrBits-1:0] EdgeNone = EptrBits'(MaxEdges);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SWEEP, S_ADD_RD, S_ADD_WR, S_RUN_INIT, S_RUN_SEED,
    S_POP, S_POP_WAIT, S_HEAD_RD, S_EDGE_RD, S_EDGE_WAIT, S_RELAX_RD,
    S_RELAX, S_QRY_RD, S_QRY_WAIT, S_DONE, S_BOOT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // latch input word
    logic sweep_start;  // begin clear sweep of heads (clr) or dist/flags (run)
    logic sweep_run;    // sweep targets dist/flags rather than heads
    logic sweep_step;
    logic add_rd;       // read head[to]
    logic add_wr;       // write edge and head
    logic seed;         // dist[target]=0, push target
    logic pop_rd;       // read dist of queue head
    logic pop;          // consume queue head, clear flag, read head list
    logic edge_rd;      // load cursor from head list
    logic relax_rd;     // read dist/flag of tail
    logic relax;        // compare and update
    logic qry_rd;
    logic qry_take;
    logic set_status;
    status_t status;
    logic out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic    sweep_done;
    logic    q_empty;
    logic    edge_end;    // cursor is empty marker
    logic    tail_ok;     // edge tail below limit
    logic    bad_ep;
    logic    bad_node;
    logic    full;
    cmd_t    cmd;
  } sts_t;

endpackage

// File: rtl/qspe_ram.sv
// ----------------------------------------------------------------------------
// qspe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module qspe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/qspe_datapath.sv
// ----------------------------------------------------------------------------
// qspe_datapath
// Graph memories, distance table, work queue and relaxation arithmetic.
// ----------------------------------------------------------------------------
module qspe_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  qspe_pkg::ctl_t                    ctl,
  output qspe_pkg::sts_t                    sts,
  input  logic [qspe_pkg::CntBits-1:0]      node_count,
  input  logic [47:0]                       in_word,
  output logic [1:0]                        out_status,
  output logic [qspe_pkg::OutBits-1:0]      out_distance,
  output logic                              out_reachable
);
  import qspe_pkg::*;

  logic [1:0]            cmd;
  logic [NodeBits-1:0]   from, to, node;
  logic [WeightBits-1:0] weight;
  logic [CntBits-1:0]    limit;
  logic [EdgeBits:0]     edge_total;
  logic                  dist_valid;   // distance table swept by a run

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd    <= in_word[1:0];
      from   <= in_word[11:2];
      to     <= in_word[21:12];
      weight <= in_word[37:22];
      node   <= in_word[47:38];
      limit  <= (node_count > CntBits'(MaxNodes)) ? CntBits'(MaxNodes) : node_count;
    end
  end

  // sweep counter; also runs the head clearing pass after reset
  logic [NodeBits:0] sw;
  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) sw <= '0;
    else if (ctl.sweep_step) sw <= sw + 1'b1;
  end
  logic [NodeBits-1:0] swa;
  assign swa = sw[NodeBits-1:0];

  // memories
  logic                 h_we;  logic [NodeBits-1:0] h_wa, h_ra;
  logic [EptrBits-1:0]  h_wd, h_rd;
  logic                 e_we;  logic [EdgeBits-1:0] e_wa, e_ra;
  logic [EntryBits-1:0] e_wd, e_rd;
  logic                 d_we;  logic [NodeBits-1:0] d_wa, d_ra;
  logic [DistBits:0]    d_wd, d_rd;   // {flag, dist}
  logic                 q_we;  logic [NodeBits-1:0] q_wa, q_ra;
  logic [NodeBits-1:0]  q_wd, q_rd;

  qspe_ram #(.Width(EptrBits),  .Depth(MaxNodes)) u_head (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  qspe_ram #(.Width(EntryBits), .Depth(MaxEdges)) u_edge (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  qspe_ram #(.Width(DistBits+1), .Depth(MaxNodes)) u_dist (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  qspe_ram #(.Width(NodeBits),  .Depth(MaxNodes)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic [NodeBits-1:0] qh, qt, u, v;
  logic [NodeBits:0]   qc;
  logic [DistBits-1:0] du;
  logic [EptrBits-1:0] cur;
  logic [WeightBits-1:0] ew;
  logic [DistBits:0]   cand;
  logic [DistBits-1:0] cand_sat;

  assign cand     = {1'b0, du} + (DistBits+1)'(ew);
  assign cand_sat = (cand > (DistBits+1)'(DistMax)) ? DistBits'(DistMax) : cand[DistBits-1:0];

  logic upd;
  assign upd = ctl.relax && (d_rd[DistBits-1:0] > cand_sat);

  always_comb begin
    h_we = 1'b0; h_wa = swa; h_wd = EdgeNone; h_ra = to;
    if (ctl.sweep_step && !ctl.sweep_run) h_we = 1'b1;
    if (ctl.add_wr) begin
      h_we = 1'b1; h_wa = to; h_wd = EptrBits'(edge_total);
    end
    if (ctl.pop) h_ra = q_rd;
    e_we = ctl.add_wr; e_wa = edge_total[EdgeBits-1:0];
    e_wd = {from, weight, h_rd};
    e_ra = cur[EdgeBits-1:0];
    d_we = 1'b0; d_wa = swa; d_wd = {1'b0, DistInf}; d_ra = node;
    if (ctl.sweep_step && ctl.sweep_run) d_we = 1'b1;
    if (ctl.seed) begin d_we = 1'b1; d_wa = node; d_wd = {1'b1, {DistBits{1'b0}}}; end
    // popped node: drop its queued flag, keep its distance
    if (ctl.pop)  begin d_we = 1'b1; d_wa = q_rd; d_wd = {1'b0, d_rd[DistBits-1:0]}; end
    if (upd)      begin d_we = 1'b1; d_wa = v; d_wd = {1'b1, cand_sat}; end
    if (ctl.pop_rd) d_ra = q_rd;
    if (ctl.relax_rd) d_ra = e_rd[EntryBits-1 -: NodeBits];
    q_we = 1'b0; q_wa = qt; q_wd = node;
    if (ctl.seed) q_we = 1'b1;
    if (upd && !d_rd[DistBits]) begin q_we = 1'b1; q_wd = v; end
    q_ra = qh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      qh <= '0; qt <= '0; qc <= '0;
      dist_valid <= 1'b0;
    end else begin
      if (ctl.sweep_start && !ctl.sweep_run) edge_total <= '0;
      if (ctl.add_wr) edge_total <= edge_total + 1'b1;
      if (ctl.sweep_start && ctl.sweep_run) begin
        qh <= '0; qt <= '0; qc <= '0;
        dist_valid <= 1'b1;
      end else begin
        if (q_we) qt <= qt + 1'b1;
        if (ctl.pop) qh <= qh + 1'b1;
        qc <= qc + (NodeBits+1)'(q_we) - (NodeBits+1)'(ctl.pop);
      end
    end
  end

  // pop_rd: d_ra=q_rd, so dist of u arrives the cycle of pop
  always_ff @(posedge clk) begin
    if (ctl.pop) begin u <= q_rd; du <= d_rd[DistBits-1:0]; end
    if (ctl.edge_rd) cur <= h_rd;             // first edge after pop
    if (ctl.relax_rd) begin ew <= e_rd[EptrBits +: WeightBits]; cur <= e_rd[EptrBits-1:0]; end
    if (ctl.edge_rd || ctl.relax_rd) v <= e_rd[EntryBits-1 -: NodeBits];
  end

  assign sts.sweep_done = (sw == (NodeBits+1)'(MaxNodes-1)) && ctl.sweep_step;
  assign sts.q_empty    = (qc == '0);
  assign sts.edge_end   = (cur == EdgeNone);
  assign sts.tail_ok    = (CntBits'(e_rd[EntryBits-1 -: NodeBits]) < limit);
  assign sts.bad_ep     = (CntBits'(from) >= limit) || (CntBits'(to) >= limit);
  assign sts.bad_node   = (CntBits'(node) >= limit);
  assign sts.full       = (edge_total == (EdgeBits+1)'(MaxEdges));
  assign sts.cmd        = cmd_t'(cmd);

  // before the first run every node reads as unreachable
  logic hit;
  assign hit = dist_valid && (d_rd[DistBits-1:0] != DistInf);

  always_ff @(posedge clk) begin
    if (ctl.qry_take) begin
      out_reachable <= hit;
      out_distance  <= hit ? d_rd[OutBits-1:0] : '0;
    end else if (ctl.load_in) begin
      out_reachable <= 1'b0;
      out_distance  <= '0;
    end
    if (ctl.load_in) out_status <= ST_OK;
    else if (ctl.set_status) out_status <= ctl.status;
  end

  logic unused_u;
  assign unused_u = ^u;

  assert property (@(posedge clk) disable iff (rst) qc <= (NodeBits+1)'(MaxNodes))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) ctl.add_wr |-> !sts.full)
    else $error("edge write while store full");
  assert property (@(posedge clk) disable iff (rst) ctl.pop |-> !sts.q_empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/qspe_ctrl.sv
// ----------------------------------------------------------------------------
// qspe_ctrl
// Command sequencer for clear, add, run and query.
// ----------------------------------------------------------------------------
module qspe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  qspe_pkg::sts_t sts,
  output qspe_pkg::ctl_t ctl
);
  import qspe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_BOOT;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.status = ST_OK;
    unique case (state)
      S_BOOT: begin
        // empty every head list once after reset
        ctl.sweep_step = 1'b1;
        if (sts.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          ctl.load_in = 1'b1;
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // dispatch on latched command
        unique case (sts.cmd)
          CMD_CLEAR: begin ctl.sweep_start = 1'b1; state_next = S_RUN_INIT; end
          CMD_ADD: begin
            if (sts.bad_ep) begin
              ctl.set_status = 1'b1; ctl.status = ST_BAD; state_next = S_DONE;
            end else if (sts.full) begin
              ctl.set_status = 1'b1; ctl.status = ST_FULL; state_next = S_DONE;
            end else state_next = S_ADD_RD;
          end
          CMD_RUN: begin
            if (sts.bad_node) begin
              ctl.set_status = 1'b1; ctl.status = ST_BAD; state_next = S_DONE;
            end else begin
              ctl.sweep_start = 1'b1; ctl.sweep_run = 1'b1; state_next = S_RUN_INIT;
            end
          end
          CMD_QUERY: begin
            if (sts.bad_node) begin
              ctl.set_status = 1'b1; ctl.status = ST_BAD; state_next = S_DONE;
            end else state_next = S_QRY_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RUN_INIT: begin
        ctl.sweep_step = 1'b1;
        ctl.sweep_run = (sts.cmd == CMD_RUN);
        if (sts.sweep_done) state_next = (sts.cmd == CMD_RUN) ? S_RUN_SEED : S_DONE;
      end
      S_ADD_RD: begin ctl.add_rd = 1'b1; state_next = S_ADD_WR; end
      S_ADD_WR: begin ctl.add_wr = 1'b1; state_next = S_DONE; end
      S_RUN_SEED: begin ctl.seed = 1'b1; state_next = S_POP; end
      S_POP: begin
        if (sts.q_empty) state_next = S_DONE;
        else state_next = S_POP_WAIT;
      end
      S_POP_WAIT: begin ctl.pop_rd = 1'b1; state_next = S_HEAD_RD; end
      S_HEAD_RD: begin ctl.pop = 1'b1; state_next = S_EDGE_RD; end
      S_EDGE_RD: begin ctl.edge_rd = 1'b1; state_next = S_EDGE_WAIT; end
      S_EDGE_WAIT: begin
        if (sts.edge_end) state_next = S_POP;
        else state_next = S_RELAX_RD;
      end
      S_RELAX_RD: begin
        // edge word valid: latch weight/next, read tail dist
        if (sts.tail_ok) begin
          ctl.relax_rd = 1'b1; state_next = S_RELAX;
        end else begin
          ctl.relax_rd = 1'b1; state_next = S_QRY_WAIT;
        end
      end
      S_QRY_WAIT: begin
        // skipped edge or query read wait
        if (sts.cmd == CMD_QUERY) begin
          ctl.qry_take = 1'b1; state_next = S_DONE;
        end else state_next = S_EDGE_WAIT;
      end
      S_RELAX: begin ctl.relax = 1'b1; state_next = S_EDGE_WAIT; end
      S_QRY_RD: begin ctl.qry_rd = 1'b1; state_next = S_QRY_WAIT; end
      S_DONE: begin
        // wait here while the previous result word is still held
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE)
    else $error("word accepted while busy");
  assert property (@(posedge clk) disable iff (rst) ctl.out_load |=> out_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst) ctl.relax |-> $past(ctl.relax_rd))
    else $error("relax without tail read");

endmodule

// File: rtl/queue_shortest_path_engine.sv
// ----------------------------------------------------------------------------
// queue_shortest_path_engine
// SPFA shortest path engine over reverse adjacency lists.
// ----------------------------------------------------------------------------
// One word in, one result word out. After reset the head lists are emptied
// in a sweep pass before the first word is accepted. Clear and run first
// sweep 1024 head or distance entries (one a cycle). A run then pops the
// queue, reads the popped node's head list and walks its edges, relaxing
// each tail distance, through the registered reads of the queue, head,
// edge and distance memories. The result word sits in an output
// register, so the next word is taken while it waits; that word's result
// then stalls until the held one is taken.
module queue_shortest_path_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] node_count_wdata,
  input  logic        node_count_we,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], edge_from[11:2], edge_to[21:12], edge_weight[37:22],
  // node_index[47:38]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], distance[27:2], reachable[28], zero fill
  output logic [31:0] m_axis_tdata
);
  import qspe_pkg::*;

  logic [CntBits-1:0] node_count;
  always_ff @(posedge clk) begin
    if (rst) node_count <= CntBits'(MaxNodes);
    else if (node_count_we) node_count <= node_count_wdata;
  end

  ctl_t ctl;
  sts_t sts;
  logic [1:0] st;
  logic [OutBits-1:0] res_dist;
  logic reach;
  logic [31:0] out_word;

  qspe_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_axis_tvalid && s_axis_tready), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .sts, .ctl);

  qspe_datapath u_dp (
    .clk, .rst, .ctl, .sts, .node_count, .in_word(s_axis_tdata),
    .out_status(st), .out_distance(res_dist), .out_reachable(reach));

  always_ff @(posedge clk) begin
    if (ctl.out_load) out_word <= {3'b000, reach, res_dist, st};
  end

  assign m_axis_tdata = out_word;

endmodule

// File: dv/qspe_checker.sv
// ----------------------------------------------------------------------------
// qspe_checker
// Watches the command and result streams of the shortest path engine, keeps
// its own copy of the graph, distances and node count, predicts one result
// word per accepted command and compares results field by field.
// ----------------------------------------------------------------------------
module qspe_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] node_count_wdata,
  input  logic        node_count_we,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count,
  output int          outstanding,
  output int          compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import qspe_pkg::*;

  typedef struct {
    status_t             status;
    logic [OutBits-1:0]  distance;
    logic                reachable;
  } answer_t;

  answer_t answers_due[$];

  int unsigned nodes_in_use;
  int unsigned head_of[MaxNodes];
  int unsigned edge_tail[MaxEdges];
  int unsigned edge_wt[MaxEdges];
  int unsigned edge_link[MaxEdges];
  int unsigned edges_stored;
  int unsigned dist_to_target[MaxNodes];
  bit          in_queue[MaxNodes];

  function automatic int unsigned usable_nodes();
    return (nodes_in_use < MaxNodes) ? nodes_in_use : MaxNodes;
  endfunction

  function automatic void drop_graph();
    for (int i = 0; i < MaxNodes; i++) head_of[i] = MaxEdges;
    edges_stored = 0;
  endfunction

  // queue-driven relaxation toward target over reverse lists
  function automatic void solve_distances(int unsigned target, int unsigned lim);
    int unsigned pend[$];
    int unsigned u, v, e;
    longint unsigned cand;
    for (int i = 0; i < MaxNodes; i++) begin
      dist_to_target[i] = DistInf;
      in_queue[i] = 0;
    end
    dist_to_target[target] = 0;
    pend.insert(pend.size(), target);
    while (pend.size() > 0) begin
      u = pend.pop_front();
      in_queue[u] = 0;
      e = head_of[u];
      while (e < MaxEdges) begin
        v = edge_tail[e];
        if (v < lim) begin
          cand = longint'(dist_to_target[u]) + edge_wt[e];
          if (cand > DistMax) cand = DistMax;
          if (longint'(dist_to_target[v]) > cand) begin
            dist_to_target[v] = int'(cand);
            if (!in_queue[v]) begin
              in_queue[v] = 1;
              if (pend.size() < MaxNodes) pend.insert(pend.size(), v);
            end
          end
        end
        e = edge_link[e];
      end
    end
  endfunction

  function automatic answer_t predict_answer(logic [47:0] word);
    answer_t a;
    cmd_t        cmd;
    int unsigned from, to, wt, node, lim;
    cmd  = cmd_t'(word[1:0]);
    from = word[11:2];
    to   = word[21:12];
    wt   = word[37:22];
    node = word[47:38];
    lim  = usable_nodes();
    a.status = ST_OK;
    a.distance = '0;
    a.reachable = 1'b0;
    case (cmd)
      CMD_CLEAR: drop_graph();
      CMD_ADD: begin
        if (from >= lim || to >= lim) a.status = ST_BAD;
        else if (edges_stored >= MaxEdges) a.status = ST_FULL;
        else begin
          edge_tail[edges_stored] = from;
          edge_wt[edges_stored]   = wt;
          edge_link[edges_stored] = head_of[to];
          head_of[to] = edges_stored;
          edges_stored++;
        end
      end
      CMD_RUN: begin
        if (node >= lim) a.status = ST_BAD;
        else solve_distances(node, lim);
      end
      default: begin
        if (node >= lim) a.status = ST_BAD;
        else if (dist_to_target[node] != DistInf) begin
          a.distance = dist_to_target[node][OutBits-1:0];
          a.reachable = 1'b1;
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      nodes_in_use = MaxNodes;
      drop_graph();
      for (int i = 0; i < MaxNodes; i++) begin
        dist_to_target[i] = DistInf;
        in_queue[i] = 0;
      end
      answers_due.delete();
      fail_count = 0;
      compared = 0;
    end else begin
      if (node_count_we) nodes_in_use = node_count_wdata;
      if (s_axis_tvalid && s_axis_tready)
        answers_due.insert(answers_due.size(), predict_answer(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          $error("result word with no command waiting: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          compared++;
          if (m_axis_tdata[1:0] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[27:2] !== want.distance) begin
            $error("distance mismatch: expected %0d, got %0d",
                   want.distance, m_axis_tdata[27:2]);
            fail_count++;
          end
          if (m_axis_tdata[28] !== want.reachable) begin
            $error("reachable mismatch: expected %0d, got %0d",
                   want.reachable, m_axis_tdata[28]);
            fail_count++;
          end
        end
      end
    end
    outstanding = answers_due.size();
  end

endmodule

// File: dv/tb_queue_shortest_path_engine.sv
// ----------------------------------------------------------------------------
// tb_queue_shortest_path_engine
// Drives edge loads, runs, queries and clears into the shortest path engine
// under several idling patterns and node counts; the checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb_queue_shortest_path_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import qspe_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [10:0] node_count_wdata = '0;
  logic        node_count_we = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count, outstanding, compared;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int words_sent = 0;
  int runs_sent = 0;
  int adds_sent = 0;

  always #5 clk = ~clk;

  queue_shortest_path_engine i_dut (.*);

  qspe_checker i_checker (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 2000;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #20ms;
    $display("tb_queue_shortest_path_engine: FAIL");
    $finish;
  end

  task automatic send_word(cmd_t cmd, int from, int to, int wt, int node);
    bit rdy;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {node[9:0], wt[15:0], to[9:0], from[9:0], cmd};
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    words_sent++;
    if (cmd == CMD_RUN) runs_sent++;
    if (cmd == CMD_ADD) adds_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // register writes only with the engine idle
  task automatic set_node_count(int n);
    drain();
    node_count_we    <= 1'b1;
    node_count_wdata <= n[10:0];
    @(posedge clk);
    node_count_we    <= 1'b0;
  endtask

  function automatic int pick_weight();
    case ($urandom_range(4))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(1, 20);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int pick_node(int n);
    if (n > 0 && $urandom_range(9) != 0) return $urandom_range(n - 1);
    return $urandom_range(1023);
  endfunction

  task automatic random_graph();
    int n, m;
    n = ($urandom_range(9) == 0) ? $urandom_range(48, 1024) : $urandom_range(1, 40);
    set_node_count(n);
    send_word(CMD_CLEAR, $urandom_range(1023), $urandom_range(1023), 0, 0);
    m = $urandom_range(0, (n < 20) ? 3 * n : 60);
    repeat (m)
      send_word(CMD_ADD, pick_node(n), pick_node(n), pick_weight(), $urandom_range(1023));
    repeat ($urandom_range(4, 12)) begin
      case ($urandom_range(7))
        0, 1: send_word(CMD_RUN, 0, 0, 0, pick_node(n));
        2: send_word(cmd_t'($urandom_range(3)), $urandom_range(1023),
                     $urandom_range(1023), $urandom_range(65535), $urandom_range(1023));
        default: send_word(CMD_QUERY, $urandom_range(1023), 0, 0, pick_node(n));
      endcase
    end
    // shrink the node count under a loaded graph
    if (n > 2 && $urandom_range(3) == 0) begin
      set_node_count($urandom_range(1, n - 1));
      send_word(CMD_RUN, 0, 0, 0, pick_node(n));
      repeat (4) send_word(CMD_QUERY, 0, 0, 0, pick_node(n));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_word(CMD_QUERY, 0, 0, 0, 0);
    send_word(CMD_ADD, 1023, 0, 65535, 0);
    send_word(CMD_ADD, 0, 1023, 0, 1023);
    send_word(CMD_ADD, 1023, 1023, 1, 0);
    send_word(CMD_RUN, 0, 0, 0, 1023);
    send_word(CMD_QUERY, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 1023);
    send_word(CMD_QUERY, 0, 0, 0, 512);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 0);         // distances survive a clear
    set_node_count(0);
    send_word(CMD_ADD, 0, 0, 5, 0);
    send_word(CMD_RUN, 0, 0, 0, 0);
    send_word(CMD_QUERY, 0, 0, 0, 0);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    set_node_count(5);
    send_word(CMD_ADD, 7, 1, 3, 0);
    send_word(CMD_ADD, 1, 7, 3, 0);
    send_word(CMD_ADD, 4, 1, 3, 0);
    send_word(CMD_ADD, 3, 4, 9, 0);
    send_word(CMD_RUN, 0, 0, 0, 9);
    send_word(CMD_RUN, 0, 0, 0, 1);
    send_word(CMD_QUERY, 0, 0, 0, 3);
    send_word(CMD_QUERY, 0, 0, 0, 2);
    send_word(CMD_QUERY, 0, 0, 0, 9);
    set_node_count(1024);

    for (int phase = 0; phase < 4; phase++) begin
      int stop_at;
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      stop_at = words_sent + 350;
      if (phase == 0) hold_asks++;
      while (words_sent < stop_at) random_graph();
    end
    set_node_count(1024);

    drain();
    repeat (50) @(posedge clk);
    $display("Sent %0d command words: %0d edge adds, %0d runs, across four idling modes.",
             words_sent, adds_sent, runs_sent);
    $display("Compared %0d result words, including zero and shrunken node counts.",
             compared);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_queue_shortest_path_engine: PASS");
    end else begin
      $display("tb_queue_shortest_path_engine: FAIL");
    end
    $finish;
  end

endmodule
